@@ rtl/event_sequence_gap_tracker_macros.svh @@
// ---------------------------------------------------------------------------
// Event sequence gap tracker assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef EVENT_SEQUENCE_GAP_TRACKER_MACROS_SVH
`define EVENT_SEQUENCE_GAP_TRACKER_MACROS_SVH

// same-cycle implication
`define ESGT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESGT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/esgt_pkg.sv @@
// ---------------------------------------------------------------------------
// Event sequence gap tracker package
// Widths, register indexes, reset values and the result beat type.
// ---------------------------------------------------------------------------
package esgt_pkg;

    localparam int KIND_COUNT = 256;
    localparam int KIND_W     = 8;
    localparam int KIND_AW    = $clog2(KIND_COUNT);
    localparam int KIND_XW    = ((KIND_AW > KIND_W) ? KIND_AW : KIND_W) + 1;

    localparam int VER_W  = 8;
    localparam int SEQ_W  = 64;
    localparam int SKIP_W = 32;
    localparam int CNT_W  = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam int RES_DEPTH = 8;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    typedef logic [KIND_XW-1:0] t_kind_x;
    typedef logic [SEQ_W:0]     t_seq_x;
    typedef logic [SEQ_W+1:0]   t_sum_x;
    typedef logic [CNT_W:0]     t_cnt_x;
    typedef logic [RES_CW-1:0]  t_res_cnt;

    localparam t_kind_x KIND_LIMIT = KIND_XW'(KIND_COUNT);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam t_res_cnt RES_CAP = RES_CW'(RES_DEPTH);
    localparam logic [RES_AW-1:0] RES_LAST = RES_AW'(RES_DEPTH - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUPPORTED_VERSION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KNOWN_VERSION     = CFG_IDX_W'(1);

    localparam logic [VER_W-1:0] MIN_VERSION_RESET = 8'd4;
    localparam logic [VER_W-1:0] MAX_VERSION_RESET = 8'd8;

    typedef struct packed {
        logic             flag_unknown_version;
        logic             flag_epoch_changed;
        logic             flag_sequence_gap;
        logic [SEQ_W-1:0] drops_total;
        logic [CNT_W-1:0] gaps_total;
        logic [CNT_W-1:0] newer_version_total;
        logic [CNT_W-1:0] user_space_total;
        logic [SEQ_W-1:0] suppressed_total;
    } t_result;

endpackage

@@ rtl/esgt_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module esgt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/esgt_fifo.sv @@
// ---------------------------------------------------------------------------
// Result buffer
// Small register FIFO holding finished result beats until taken.
// ---------------------------------------------------------------------------
module esgt_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  esgt_pkg::t_result i_push_data,
    input  logic             i_pop,
    output logic             o_valid,
    output esgt_pkg::t_result o_data
);

    esgt_pkg::t_result              r_mem [esgt_pkg::RES_DEPTH];
    logic [esgt_pkg::RES_AW-1:0]    r_wr_ptr;
    logic [esgt_pkg::RES_AW-1:0]    r_rd_ptr;
    esgt_pkg::t_res_cnt             r_count;
    logic [esgt_pkg::RES_AW-1:0]    n_wr_ptr;
    logic [esgt_pkg::RES_AW-1:0]    n_rd_ptr;
    esgt_pkg::t_res_cnt             n_count;
    logic                           pop;

    assign o_valid = (r_count != '0);
    assign pop     = i_pop && o_valid;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == esgt_pkg::RES_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == esgt_pkg::RES_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ rtl/event_sequence_gap_tracker.sv @@
// ---------------------------------------------------------------------------
// Event sequence gap tracker
// Checks event records for lost or reordered events and keeps totals.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one event record per beat.
//   Output channel (o_out_valid / i_out_stall) gives one result beat per
//   record, in order: three flags and the saturating running totals.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the version limits;
//   ready is always high, write only while no record is in flight.
//   Throughput: one record per cycle while o_in_stall is low. The per-type
//   table is one RAM with a registered read, read when a record is taken
//   and written in the next cycle; a same-type record right behind is fed
//   from a bypass register. A result passes the RAM read and state update,
//   compare, gap and excess, accumulate and result buffer registers in order.
//   A stalled receiver fills an 8-entry result buffer; o_in_stall rises once
//   eight records are in flight and falls as results are taken.
//   Reset (synchronous, i_rst_n low): totals, epoch tracking and type valid
//   bits clear at once; the table RAM is not swept and no cycles are lost.
// ---------------------------------------------------------------------------
`include "event_sequence_gap_tracker_macros.svh"

module event_sequence_gap_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [esgt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [esgt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kernel_sequenced,
    input  logic [esgt_pkg::VER_W-1:0]          i_message_version,
    input  logic [esgt_pkg::SEQ_W-1:0]          i_connection_epoch,
    input  logic [esgt_pkg::SEQ_W-1:0]          i_global_seq,
    input  logic [esgt_pkg::SKIP_W-1:0]         i_skipped_global,
    input  logic [esgt_pkg::KIND_W-1:0]         i_event_kind,
    input  logic [esgt_pkg::SEQ_W-1:0]          i_kind_seq,
    input  logic [esgt_pkg::SKIP_W-1:0]         i_skipped_kind,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_flag_unknown_version,
    output logic                                o_flag_epoch_changed,
    output logic                                o_flag_sequence_gap,
    output logic [esgt_pkg::SEQ_W-1:0]          o_drops_total,
    output logic [esgt_pkg::CNT_W-1:0]          o_gaps_total,
    output logic [esgt_pkg::CNT_W-1:0]          o_newer_version_total,
    output logic [esgt_pkg::CNT_W-1:0]          o_user_space_total,
    output logic [esgt_pkg::SEQ_W-1:0]          o_suppressed_total
);

    // config
    logic [esgt_pkg::VER_W-1:0]  r_min_version;
    logic [esgt_pkg::VER_W-1:0]  r_max_version;

    // flow control
    esgt_pkg::t_res_cnt          r_inflight;
    esgt_pkg::t_res_cnt          n_inflight;
    logic                        r_in_stall;
    logic                        in_accept;
    logic                        out_deliver;

    // tracking state
    logic                              r_epoch_valid;
    logic [esgt_pkg::SEQ_W-1:0]        r_current_epoch;
    logic [esgt_pkg::SEQ_W-1:0]        r_last_global;
    logic [esgt_pkg::CNT_W-1:0]        r_seen_count;
    logic [esgt_pkg::CNT_W-1:0]        n_seen_count;
    logic [esgt_pkg::KIND_COUNT-1:0]   r_kind_valid;
    logic [esgt_pkg::KIND_COUNT-1:0]   n_kind_valid;

    // totals
    logic [esgt_pkg::SEQ_W-1:0]  r_drop_sum;
    logic [esgt_pkg::CNT_W-1:0]  r_gap_count;
    logic [esgt_pkg::CNT_W-1:0]  r_newer_count;
    logic [esgt_pkg::CNT_W-1:0]  r_user_count;
    logic [esgt_pkg::SEQ_W-1:0]  r_suppressed_sum;

    // table RAM and bypass
    esgt_pkg::t_kind_x             in_kind_x;
    logic [esgt_pkg::KIND_AW-1:0]  ram_raddr;
    logic [esgt_pkg::SEQ_W-1:0]    ram_rdata;
    logic                          r_fwd_hit;
    logic [esgt_pkg::SEQ_W-1:0]    r_fwd_seq;

    // stage 1: record, table data
    logic                          r_s1_valid;
    logic                          r_s1_kernel_sequenced;
    logic [esgt_pkg::VER_W-1:0]    r_s1_message_version;
    logic [esgt_pkg::SEQ_W-1:0]    r_s1_connection_epoch;
    logic [esgt_pkg::SEQ_W-1:0]    r_s1_global_seq;
    logic [esgt_pkg::SKIP_W-1:0]   r_s1_skipped_global;
    logic [esgt_pkg::KIND_W-1:0]   r_s1_event_kind;
    logic [esgt_pkg::SEQ_W-1:0]    r_s1_kind_seq;
    logic [esgt_pkg::SKIP_W-1:0]   r_s1_skipped_kind;

    esgt_pkg::t_kind_x             s1_kind_x;
    logic [esgt_pkg::KIND_AW-1:0]  s1_idx;
    logic                          s1_in_range;
    logic                          s1_supported;
    logic                          s1_epoch_chg;
    logic                          s1_g_en;
    logic                          s1_k_en;
    logic                          s1_ram_we;
    logic [esgt_pkg::SEQ_W-1:0]    s1_kind_last;
    logic [esgt_pkg::CNT_W-1:0]    s1_seen_base;
    esgt_pkg::t_seq_x              s1_exp_g;
    esgt_pkg::t_seq_x              s1_exp_k;

    // stage 2: compares
    logic                          r_s2_valid;
    logic                          r_s2_f_ver;
    logic                          r_s2_f_epoch;
    logic                          r_s2_g_en;
    logic                          r_s2_k_en;
    logic                          r_s2_user_inc;
    logic                          r_s2_newer_inc;
    logic [esgt_pkg::SEQ_W-1:0]    r_s2_global_seq;
    logic [esgt_pkg::SEQ_W-1:0]    r_s2_last_global;
    logic [esgt_pkg::SEQ_W-1:0]    r_s2_kind_seq;
    logic [esgt_pkg::SKIP_W-1:0]   r_s2_skipped_global;
    esgt_pkg::t_seq_x              r_s2_exp_g;
    esgt_pkg::t_seq_x              r_s2_exp_k;

    logic                          s2_g_above;
    logic                          s2_k_above;

    // stage 3: gaps and excesses
    logic                          r_s3_valid;
    logic                          r_s3_f_ver;
    logic                          r_s3_f_epoch;
    logic                          r_s3_gap_g;
    logic                          r_s3_gap_k;
    logic                          r_s3_user_inc;
    logic                          r_s3_newer_inc;
    logic [esgt_pkg::SEQ_W-1:0]    r_s3_ex_g;
    logic [esgt_pkg::SEQ_W-1:0]    r_s3_ex_k;
    logic [esgt_pkg::SKIP_W-1:0]   r_s3_supp_add;

    // stage 4: accumulate
    logic                          r_s4_valid;
    logic                          r_s4_f_ver;
    logic                          r_s4_f_epoch;
    logic                          r_s4_f_gap;
    logic [1:0]                    r_s4_gap_n;
    logic                          r_s4_user_inc;
    logic                          r_s4_newer_inc;
    esgt_pkg::t_seq_x              r_s4_ex_sum;
    logic [esgt_pkg::SKIP_W-1:0]   r_s4_supp_add;

    esgt_pkg::t_sum_x              s4_drop_x;
    esgt_pkg::t_cnt_x              s4_gap_x;
    esgt_pkg::t_seq_x              s4_supp_x;
    logic [esgt_pkg::SEQ_W-1:0]    n_drop_sum;
    logic [esgt_pkg::CNT_W-1:0]    n_gap_count;
    logic [esgt_pkg::CNT_W-1:0]    n_newer_count;
    logic [esgt_pkg::CNT_W-1:0]    n_user_count;
    logic [esgt_pkg::SEQ_W-1:0]    n_suppressed_sum;
    esgt_pkg::t_result             push_data;
    esgt_pkg::t_result             out_data;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_stall;
    assign in_accept   = i_in_valid && !r_in_stall;
    assign out_deliver = o_out_valid && !i_out_stall;

    always_comb begin
        n_inflight = r_inflight;
        if (in_accept && !out_deliver) begin
            n_inflight = r_inflight + 1'b1;
        end else if (!in_accept && out_deliver) begin
            n_inflight = r_inflight - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight    <= '0;
            r_in_stall    <= 1'b0;
            r_min_version <= esgt_pkg::MIN_VERSION_RESET;
            r_max_version <= esgt_pkg::MAX_VERSION_RESET;
        end else begin
            r_inflight <= n_inflight;
            r_in_stall <= (n_inflight >= esgt_pkg::RES_CAP);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    esgt_pkg::CFG_MIN_SUPPORTED_VERSION: r_min_version <= i_cfg_data;
                    esgt_pkg::CFG_MAX_KNOWN_VERSION:     r_max_version <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // per-type table
    // ------------------------------------------------------------------
    assign in_kind_x = esgt_pkg::t_kind_x'(i_event_kind);
    assign ram_raddr = in_kind_x[esgt_pkg::KIND_AW-1:0];

    esgt_ram #(
        .WIDTH (esgt_pkg::SEQ_W),
        .DEPTH (esgt_pkg::KIND_COUNT)
    ) u_kind_ram (
        .i_clk   (i_clk),
        .i_we    (s1_ram_we),
        .i_waddr (s1_idx),
        .i_wdata (r_s1_kind_seq),
        .i_re    (in_accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // stage 1
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kernel_sequenced <= i_kernel_sequenced;
            r_s1_message_version  <= i_message_version;
            r_s1_connection_epoch <= i_connection_epoch;
            r_s1_global_seq       <= i_global_seq;
            r_s1_skipped_global   <= i_skipped_global;
            r_s1_event_kind       <= i_event_kind;
            r_s1_kind_seq         <= i_kind_seq;
            r_s1_skipped_kind     <= i_skipped_kind;
        end
        r_fwd_seq <= r_s1_kind_seq;
    end

    always_comb begin
        s1_kind_x    = esgt_pkg::t_kind_x'(r_s1_event_kind);
        s1_idx       = s1_kind_x[esgt_pkg::KIND_AW-1:0];
        s1_in_range  = (s1_kind_x < esgt_pkg::KIND_LIMIT);
        s1_supported = (r_s1_message_version >= r_min_version);
        s1_epoch_chg = r_s1_kernel_sequenced && r_epoch_valid
                       && (r_s1_connection_epoch != r_current_epoch);
        s1_g_en      = r_s1_kernel_sequenced && s1_supported && !s1_epoch_chg
                       && (r_seen_count != '0);
        s1_k_en      = r_s1_kernel_sequenced && s1_in_range && !s1_epoch_chg
                       && r_kind_valid[s1_idx];
        s1_ram_we    = r_s1_valid && r_s1_kernel_sequenced && s1_in_range;
        s1_kind_last = r_fwd_hit ? r_fwd_seq : ram_rdata;
        s1_exp_g     = esgt_pkg::t_seq_x'(r_last_global)
                       + esgt_pkg::t_seq_x'(r_s1_skipped_global)
                       + esgt_pkg::t_seq_x'(1);
        s1_exp_k     = esgt_pkg::t_seq_x'(s1_kind_last)
                       + esgt_pkg::t_seq_x'(r_s1_skipped_kind)
                       + esgt_pkg::t_seq_x'(1);
        s1_seen_base = s1_epoch_chg ? '0 : r_seen_count;
        n_seen_count = (s1_seen_base == '1) ? s1_seen_base : s1_seen_base + 1'b1;

        n_kind_valid = r_kind_valid;
        if (r_s1_valid && s1_epoch_chg) begin
            n_kind_valid = '0;
        end
        if (s1_ram_we) begin
            n_kind_valid[s1_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_fwd_hit       <= 1'b0;
            r_epoch_valid   <= 1'b0;
            r_current_epoch <= '0;
            r_last_global   <= '0;
            r_seen_count    <= '0;
            r_kind_valid    <= '0;
        end else begin
            r_s1_valid   <= in_accept;
            r_fwd_hit    <= in_accept && s1_ram_we && (i_event_kind == r_s1_event_kind);
            r_kind_valid <= n_kind_valid;
            if (r_s1_valid) begin
                r_seen_count <= n_seen_count;
                if (r_s1_kernel_sequenced) begin
                    r_epoch_valid   <= 1'b1;
                    r_current_epoch <= r_s1_connection_epoch;
                    r_last_global   <= r_s1_global_seq;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_s2_f_ver          <= r_s1_kernel_sequenced && !s1_supported;
        r_s2_f_epoch        <= s1_epoch_chg;
        r_s2_g_en           <= s1_g_en;
        r_s2_k_en           <= s1_k_en;
        r_s2_user_inc       <= !r_s1_kernel_sequenced;
        r_s2_newer_inc      <= r_s1_kernel_sequenced && s1_supported
                               && (r_s1_message_version > r_max_version);
        r_s2_global_seq     <= r_s1_global_seq;
        r_s2_last_global    <= r_last_global;
        r_s2_kind_seq       <= r_s1_kind_seq;
        r_s2_skipped_global <= r_s1_skipped_global;
        r_s2_exp_g          <= s1_exp_g;
        r_s2_exp_k          <= s1_exp_k;
    end

    assign s2_g_above = (esgt_pkg::t_seq_x'(r_s2_global_seq) > r_s2_exp_g);
    assign s2_k_above = (esgt_pkg::t_seq_x'(r_s2_kind_seq) > r_s2_exp_k);

    // ------------------------------------------------------------------
    // stage 3
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_s3_f_ver     <= r_s2_f_ver;
        r_s3_f_epoch   <= r_s2_f_epoch;
        r_s3_user_inc  <= r_s2_user_inc;
        r_s3_newer_inc <= r_s2_newer_inc;
        r_s3_gap_g     <= r_s2_g_en
                          && (s2_g_above || (r_s2_global_seq <= r_s2_last_global));
        r_s3_gap_k     <= r_s2_k_en && s2_k_above;
        r_s3_ex_g      <= (r_s2_g_en && s2_g_above)
                          ? r_s2_global_seq - r_s2_exp_g[esgt_pkg::SEQ_W-1:0] : '0;
        r_s3_ex_k      <= (r_s2_k_en && s2_k_above)
                          ? r_s2_kind_seq - r_s2_exp_k[esgt_pkg::SEQ_W-1:0] : '0;
        r_s3_supp_add  <= r_s2_g_en ? r_s2_skipped_global : '0;
    end

    // ------------------------------------------------------------------
    // stage 4
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_s4_f_ver     <= r_s3_f_ver;
        r_s4_f_epoch   <= r_s3_f_epoch;
        r_s4_f_gap     <= r_s3_gap_g || r_s3_gap_k;
        r_s4_gap_n     <= {1'b0, r_s3_gap_g} + {1'b0, r_s3_gap_k};
        r_s4_user_inc  <= r_s3_user_inc;
        r_s4_newer_inc <= r_s3_newer_inc;
        r_s4_ex_sum    <= esgt_pkg::t_seq_x'(r_s3_ex_g) + esgt_pkg::t_seq_x'(r_s3_ex_k);
        r_s4_supp_add  <= r_s3_supp_add;
    end

    always_comb begin
        s4_drop_x = esgt_pkg::t_sum_x'(r_drop_sum) + esgt_pkg::t_sum_x'(r_s4_ex_sum);
        s4_gap_x  = esgt_pkg::t_cnt_x'(r_gap_count) + esgt_pkg::t_cnt_x'(r_s4_gap_n);
        s4_supp_x = esgt_pkg::t_seq_x'(r_suppressed_sum)
                    + esgt_pkg::t_seq_x'(r_s4_supp_add);

        n_drop_sum       = (s4_drop_x[esgt_pkg::SEQ_W+1:esgt_pkg::SEQ_W] != 2'b00)
                           ? '1 : s4_drop_x[esgt_pkg::SEQ_W-1:0];
        n_gap_count      = s4_gap_x[esgt_pkg::CNT_W] ? '1 : s4_gap_x[esgt_pkg::CNT_W-1:0];
        n_suppressed_sum = s4_supp_x[esgt_pkg::SEQ_W]
                           ? '1 : s4_supp_x[esgt_pkg::SEQ_W-1:0];
        n_newer_count    = (r_s4_newer_inc && (r_newer_count != '1))
                           ? r_newer_count + 1'b1 : r_newer_count;
        n_user_count     = (r_s4_user_inc && (r_user_count != '1))
                           ? r_user_count + 1'b1 : r_user_count;

        push_data.flag_unknown_version = r_s4_f_ver;
        push_data.flag_epoch_changed   = r_s4_f_epoch;
        push_data.flag_sequence_gap    = r_s4_f_gap;
        push_data.drops_total          = n_drop_sum;
        push_data.gaps_total           = n_gap_count;
        push_data.newer_version_total  = n_newer_count;
        push_data.user_space_total     = n_user_count;
        push_data.suppressed_total     = n_suppressed_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid       <= 1'b0;
            r_s3_valid       <= 1'b0;
            r_s4_valid       <= 1'b0;
            r_drop_sum       <= '0;
            r_gap_count      <= '0;
            r_newer_count    <= '0;
            r_user_count     <= '0;
            r_suppressed_sum <= '0;
        end else begin
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            if (r_s4_valid) begin
                r_drop_sum       <= n_drop_sum;
                r_gap_count      <= n_gap_count;
                r_newer_count    <= n_newer_count;
                r_user_count     <= n_user_count;
                r_suppressed_sum <= n_suppressed_sum;
            end
        end
    end

    // ------------------------------------------------------------------
    // result buffer
    // ------------------------------------------------------------------
    esgt_fifo u_result_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s4_valid),
        .i_push_data (push_data),
        .i_pop       (!i_out_stall),
        .o_valid     (o_out_valid),
        .o_data      (out_data)
    );

    assign o_flag_unknown_version = out_data.flag_unknown_version;
    assign o_flag_epoch_changed   = out_data.flag_epoch_changed;
    assign o_flag_sequence_gap    = out_data.flag_sequence_gap;
    assign o_drops_total          = out_data.drops_total;
    assign o_gaps_total           = out_data.gaps_total;
    assign o_newer_version_total  = out_data.newer_version_total;
    assign o_user_space_total     = out_data.user_space_total;
    assign o_suppressed_total     = out_data.suppressed_total;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ESGT_ASSERT_IMP(a_out_backed, o_out_valid, r_inflight != '0, "result beat with nothing in flight")
    `ESGT_ASSERT_NXT(a_epoch_restart, r_s1_valid && s1_epoch_chg, r_seen_count == esgt_pkg::CNT_ONE, "epoch change did not restart count")
    `ESGT_ASSERT_IMP(a_fwd_source, r_fwd_hit, $past(r_s1_valid), "bypass hit without a table write")
    `ESGT_ASSERT_NXT(a_kind_marked, s1_ram_we, r_kind_valid[$past(s1_idx)], "table write left type invalid")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Event sequence gap tracker testbench
// A directed set of records runs first, then about 700 random records over
// several version-limit settings. A scoreboard predicts every result beat
// and compares it field by field. The sender idles and the receiver stalls at random.
// ---------------------------------------------------------------------------
import esgt_pkg::*;

typedef struct {
    logic                  kseq;
    logic [VER_W-1:0]      ver;
    logic [SEQ_W-1:0]      epoch;
    logic [SEQ_W-1:0]      gseq;
    logic [SKIP_W-1:0]     gskip;
    logic [KIND_W-1:0]     kind;
    logic [SEQ_W-1:0]      tseq;
    logic [SKIP_W-1:0]     tskip;
} ev_t;

class gap_scoreboard;
    logic [VER_W-1:0]  min_ver;
    logic [VER_W-1:0]  max_ver;
    logic              epoch_ok;
    logic [SEQ_W-1:0]  cur_epoch;
    logic [SEQ_W-1:0]  last_gseq;
    logic [CNT_W-1:0]  seen;
    logic              kind_ok [KIND_COUNT];
    logic [SEQ_W-1:0]  kind_last [KIND_COUNT];
    logic [SEQ_W-1:0]  drops;
    logic [SEQ_W-1:0]  suppressed;
    logic [CNT_W-1:0]  gaps;
    logic [CNT_W-1:0]  newer;
    logic [CNT_W-1:0]  users;
    t_result           expected_q[$];
    int                errors;
    int                checked;

    function new();
        min_ver    = MIN_VERSION_RESET;
        max_ver    = MAX_VERSION_RESET;
        epoch_ok   = 1'b0;
        cur_epoch  = '0;
        last_gseq  = '0;
        seen       = '0;
        drops      = '0;
        suppressed = '0;
        gaps       = '0;
        newer      = '0;
        users      = '0;
        errors     = 0;
        checked    = 0;
        foreach (kind_ok[k]) begin
            kind_ok[k]   = 1'b0;
            kind_last[k] = '0;
        end
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        if (idx == CFG_MIN_SUPPORTED_VERSION) begin
            min_ver = d;
        end else if (idx == CFG_MAX_KNOWN_VERSION) begin
            max_ver = d;
        end
    endfunction

    function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function logic [SEQ_W-1:0] sat_add(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SEQ_W] ? '1 : s[SEQ_W-1:0];
    endfunction

    // seq beyond last + 1 + skip, the sum taken without overflow
    function bit past_expected(logic [SEQ_W-1:0] last, logic [SKIP_W-1:0] skip,
                               logic [SEQ_W-1:0] seq, output logic [SEQ_W-1:0] excess);
        logic [SEQ_W+1:0] target;
        target = {2'b00, last} + (SEQ_W+2)'(1) + (SEQ_W+2)'(skip);
        excess = seq - target[SEQ_W-1:0];
        return ({2'b00, seq} > target);
    endfunction

    function void note_event(ev_t e);
        t_result          r;
        logic             supported;
        logic [SEQ_W-1:0] excess;
        r = '0;
        if (!e.kseq) begin
            users = sat_inc(users);
            seen  = sat_inc(seen);
        end else begin
            supported = (e.ver >= min_ver);
            if (!supported) begin
                r.flag_unknown_version = 1'b1;
            end else if (e.ver > max_ver) begin
                newer = sat_inc(newer);
            end
            if (!epoch_ok) begin
                cur_epoch = e.epoch;
                epoch_ok  = 1'b1;
            end else if (e.epoch != cur_epoch) begin
                r.flag_epoch_changed = 1'b1;
                cur_epoch = e.epoch;
                last_gseq = '0;
                seen      = '0;
                foreach (kind_ok[k]) kind_ok[k] = 1'b0;
            end
            if (seen != 0 && supported) begin
                if (past_expected(last_gseq, e.gskip, e.gseq, excess)) begin
                    drops = sat_add(drops, excess);
                    gaps  = sat_inc(gaps);
                    r.flag_sequence_gap = 1'b1;
                end else if (e.gseq <= last_gseq) begin
                    gaps  = sat_inc(gaps);
                    r.flag_sequence_gap = 1'b1;
                end
                suppressed = sat_add(suppressed, SEQ_W'(e.gskip));
            end
            if (int'(e.kind) < KIND_COUNT) begin
                if (kind_ok[e.kind] &&
                    past_expected(kind_last[e.kind], e.tskip, e.tseq, excess)) begin
                    drops = sat_add(drops, excess);
                    gaps  = sat_inc(gaps);
                    r.flag_sequence_gap = 1'b1;
                end
                kind_last[e.kind] = e.tseq;
                kind_ok[e.kind]   = 1'b1;
            end
            last_gseq = e.gseq;
            seen      = sat_inc(seen);
        end
        r.drops_total         = drops;
        r.gaps_total          = gaps;
        r.newer_version_total = newer;
        r.user_space_total    = users;
        r.suppressed_total    = suppressed;
        expected_q.push_back(r);
    endfunction

    function void compare(string name, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing pending", $time);
            return;
        end
        want = expected_q.pop_front();
        checked++;
        compare("flag_unknown_version", SEQ_W'(want.flag_unknown_version),
                SEQ_W'(got.flag_unknown_version));
        compare("flag_epoch_changed", SEQ_W'(want.flag_epoch_changed),
                SEQ_W'(got.flag_epoch_changed));
        compare("flag_sequence_gap", SEQ_W'(want.flag_sequence_gap),
                SEQ_W'(got.flag_sequence_gap));
        compare("drops_total", want.drops_total, got.drops_total);
        compare("gaps_total", SEQ_W'(want.gaps_total), SEQ_W'(got.gaps_total));
        compare("newer_version_total", SEQ_W'(want.newer_version_total),
                SEQ_W'(got.newer_version_total));
        compare("user_space_total", SEQ_W'(want.user_space_total),
                SEQ_W'(got.user_space_total));
        compare("suppressed_total", want.suppressed_total, got.suppressed_total);
    endfunction
endclass

module tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 86;
    localparam int HOLD_CYCLES    = 80;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_kernel_sequenced;
    logic [VER_W-1:0]       i_message_version;
    logic [SEQ_W-1:0]       i_connection_epoch;
    logic [SEQ_W-1:0]       i_global_seq;
    logic [SKIP_W-1:0]      i_skipped_global;
    logic [KIND_W-1:0]      i_event_kind;
    logic [SEQ_W-1:0]       i_kind_seq;
    logic [SKIP_W-1:0]      i_skipped_kind;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_flag_unknown_version;
    logic                   o_flag_epoch_changed;
    logic                   o_flag_sequence_gap;
    logic [SEQ_W-1:0]       o_drops_total;
    logic [CNT_W-1:0]       o_gaps_total;
    logic [CNT_W-1:0]       o_newer_version_total;
    logic [CNT_W-1:0]       o_user_space_total;
    logic [SEQ_W-1:0]       o_suppressed_total;

    event_sequence_gap_tracker u_top (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_kernel_sequenced     (i_kernel_sequenced),
        .i_message_version      (i_message_version),
        .i_connection_epoch     (i_connection_epoch),
        .i_global_seq           (i_global_seq),
        .i_skipped_global       (i_skipped_global),
        .i_event_kind           (i_event_kind),
        .i_kind_seq             (i_kind_seq),
        .i_skipped_kind         (i_skipped_kind),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_flag_unknown_version (o_flag_unknown_version),
        .o_flag_epoch_changed   (o_flag_epoch_changed),
        .o_flag_sequence_gap    (o_flag_sequence_gap),
        .o_drops_total          (o_drops_total),
        .o_gaps_total           (o_gaps_total),
        .o_newer_version_total  (o_newer_version_total),
        .o_user_space_total     (o_user_space_total),
        .o_suppressed_total     (o_suppressed_total)
    );

    gap_scoreboard sb = new();

    logic              calm;
    logic              hold_req;
    logic              hold_taken;
    int                idle_cycles;
    int                sent;
    int                cfg_writes;
    ev_t               obs_event;
    t_result           obs_result;

    logic [SEQ_W-1:0]  gen_epoch;
    logic [SEQ_W-1:0]  gen_glast;
    logic [SEQ_W-1:0]  gen_klast [KIND_COUNT];
    bit                gen_kused [KIND_COUNT];

    logic [VER_W-1:0]  min_set [PHASES];
    logic [VER_W-1:0]  max_set [PHASES];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        hold_taken  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_taken = 1'b1;
            end else begin
                i_out_stall = i_rst_n && !calm && ($urandom_range(0, 99) < 26);
            end
        end
    end

    // accepted beats: results checked before the new record is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_limit(i_cfg_index, i_cfg_data);
                cfg_writes++;
            end
            if (o_out_valid && !i_out_stall) begin
                obs_result.flag_unknown_version = o_flag_unknown_version;
                obs_result.flag_epoch_changed   = o_flag_epoch_changed;
                obs_result.flag_sequence_gap    = o_flag_sequence_gap;
                obs_result.drops_total          = o_drops_total;
                obs_result.gaps_total           = o_gaps_total;
                obs_result.newer_version_total  = o_newer_version_total;
                obs_result.user_space_total     = o_user_space_total;
                obs_result.suppressed_total     = o_suppressed_total;
                sb.check_result(obs_result);
            end
            if (i_in_valid && !o_in_stall) begin
                obs_event.kseq  = i_kernel_sequenced;
                obs_event.ver   = i_message_version;
                obs_event.epoch = i_connection_epoch;
                obs_event.gseq  = i_global_seq;
                obs_event.gskip = i_skipped_global;
                obs_event.kind  = i_event_kind;
                obs_event.tseq  = i_kind_seq;
                obs_event.tskip = i_skipped_kind;
                sb.note_event(obs_event);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired at %0t with %0d results pending",
                     $time, sb.expected_q.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic logic [SEQ_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [SKIP_W-1:0] pick_skip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return '0;
        if (r < 95) return SKIP_W'($urandom_range(1, 5));
        return $urandom;
    endfunction

    function automatic ev_t make_event(logic k, logic [VER_W-1:0] v, logic [SEQ_W-1:0] ep,
                                       logic [SEQ_W-1:0] g, logic [SKIP_W-1:0] gs,
                                       logic [KIND_W-1:0] kd, logic [SEQ_W-1:0] t,
                                       logic [SKIP_W-1:0] ts);
        ev_t e;
        e.kseq = k; e.ver = v; e.epoch = ep; e.gseq = g;
        e.gskip = gs; e.kind = kd; e.tseq = t; e.tskip = ts;
        return e;
    endfunction

    // mostly well-formed streams with random content, some noise and breaks
    function automatic ev_t next_event();
        ev_t              e;
        int               pick;
        int               r;
        logic [SEQ_W-1:0] base;
        pick    = $urandom_range(0, 99);
        e.kseq  = 1'b1;
        e.ver   = ($urandom_range(0, 99) < 85) ?
                  VER_W'($urandom_range(int'(sb.max_ver), int'(sb.min_ver))) :
                  VER_W'($urandom_range(0, 255));
        if (pick < 12) begin
            e.kseq  = (pick < 6) ? 1'($urandom) : 1'b0;
            e.ver   = VER_W'($urandom);
            e.epoch = rand64();
            e.gseq  = rand64();
            e.gskip = $urandom;
            e.kind  = KIND_W'($urandom);
            e.tseq  = rand64();
            e.tskip = $urandom;
            return e;
        end
        if (pick < 15) gen_epoch = rand64();
        e.epoch = gen_epoch;
        e.gskip = pick_skip();
        e.gseq  = gen_glast + SEQ_W'(1) + SEQ_W'(e.gskip);
        r = $urandom_range(0, 99);
        if (r < 8) begin
            e.gseq = e.gseq + SEQ_W'($urandom_range(1, 50));
        end else if (r < 13) begin
            e.gseq = gen_glast - SEQ_W'($urandom_range(0, 20));
        end else if (r < 15) begin
            e.gseq = '1 - SEQ_W'($urandom_range(0, 5));
        end
        e.kind  = ($urandom_range(0, 99) < 70) ? KIND_W'($urandom_range(0, 15)) :
                  KIND_W'($urandom_range(0, 255));
        e.tskip = pick_skip();
        base    = gen_kused[e.kind] ? gen_klast[e.kind] : rand64();
        e.tseq  = base + SEQ_W'(1) + SEQ_W'(e.tskip);
        if ($urandom_range(0, 99) < 8) e.tseq = e.tseq + SEQ_W'($urandom_range(1, 50));
        gen_glast          = e.gseq;
        gen_klast[e.kind]  = e.tseq;
        gen_kused[e.kind]  = 1'b1;
        return e;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_event(ev_t e);
        while (!calm && $urandom_range(0, 99) < 26) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kernel_sequenced = e.kseq;
        i_message_version  = e.ver;
        i_connection_epoch = e.epoch;
        i_global_seq       = e.gseq;
        i_skipped_global   = e.gskip;
        i_event_kind       = e.kind;
        i_kind_seq         = e.tseq;
        i_skipped_kind     = e.tskip;
        i_in_valid         = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        logic [SEQ_W-1:0] ep;
        ep = SEQ_W'(1);
        // user-space record before any kernel record, all other fields high
        send_event(make_event(1'b0, '1, '1, '1, '1, '1, '1, '1));
        send_event(make_event(1'b1, 8'd4, ep, 64'd10, '0, 8'd0, 64'd5, '0));
        send_event(make_event(1'b1, 8'd8, ep, 64'd11, '0, 8'd0, 64'd6, '0));
        send_event(make_event(1'b1, 8'd5, ep, 64'd15, 32'd3, 8'd0, 64'd9, 32'd2));
        send_event(make_event(1'b1, 8'd6, ep, 64'd100, '0, 8'd1, 64'd0, '0));
        send_event(make_event(1'b1, 8'd6, ep, 64'd50, '0, 8'd1, 64'd1, '0));
        send_event(make_event(1'b1, 8'd6, ep, 64'd50, '0, 8'd1, 64'd5, '0));
        send_event(make_event(1'b1, 8'd3, ep, 64'd51, '0, 8'd1, 64'd6, '0));
        send_event(make_event(1'b1, 8'd9, ep, 64'd52, '0, 8'd1, 64'd7, '0));
        send_event(make_event(1'b1, 8'd0, ep, 64'd53, '0, 8'd1, 64'd8, '0));
        send_event(make_event(1'b1, 8'd255, ep, 64'd54, '0, 8'd1, 64'd9, '0));
        // epoch change clears the type table
        send_event(make_event(1'b1, 8'd4, '1, 64'd7, '0, 8'd0, 64'd100, '0));
        send_event(make_event(1'b1, 8'd4, '1, 64'd8, '0, 8'd0, 64'd101, '0));
        send_event(make_event(1'b1, 8'd4, '1, '1 - 64'd3, '0, 8'd255, '1, '0));
        // expected numbers past 64 bits
        send_event(make_event(1'b1, 8'd4, '1, '1, '1, 8'd255, 64'd3, '1));
        send_event(make_event(1'b1, 8'd4, '1, 64'd2, '0, 8'd2, 64'd0, '0));
        // two huge excesses saturate the drop total
        send_event(make_event(1'b1, 8'd4, '1, '1, '0, 8'd2, '1, '0));
        send_event(make_event(1'b1, 8'd7, '1, 64'd0, '1, 8'd3, 64'd0, '1));
        send_event(make_event(1'b0, 8'd0, '0, '0, '0, 8'd0, '0, '0));
        send_event(make_event(1'b1, 8'd4, '0, 64'd0, '0, 8'd128, 64'd0, '0));
        send_event(make_event(1'b1, 8'd4, '0, 64'd1, '0, 8'd128, 64'd1, '0));
        i_in_valid = 1'b0;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        i_in_valid         = 1'b0;
        i_kernel_sequenced = 1'b0;
        i_message_version  = '0;
        i_connection_epoch = '0;
        i_global_seq       = '0;
        i_skipped_global   = '0;
        i_event_kind       = '0;
        i_kind_seq         = '0;
        i_skipped_kind     = '0;
        calm               = 1'b0;
        hold_req           = 1'b0;
        sent               = 0;
        gen_epoch          = rand64();
        gen_glast          = rand64();
        foreach (gen_kused[k]) gen_kused[k] = 1'b0;

        min_set = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd4};
        max_set = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd8};
        for (int p = 4; p < 7; p++) begin
            min_set[p] = VER_W'($urandom_range(0, 12));
            max_set[p] = VER_W'($urandom_range(0, 255));
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            write_limit(CFG_MIN_SUPPORTED_VERSION, min_set[p]);
            write_limit(CFG_MAX_KNOWN_VERSION, max_set[p]);
            calm = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == 20) hold_req = 1'b1;
                if (p == 3 && i == 40) drain_results();
                send_event(next_event());
            end
            calm = 1'b0;
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        $display("tb: %0d records over %0d version-limit settings, %0d register writes",
                 sent, PHASES + 1, cfg_writes);
        $display("tb: %0d result beats compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
